### rtl/qt_pkg.sv
// ----------------------------------------------------------------------------
// qt_pkg
// Shared types and constants for the quadrature tachometer: quadrature
// direction table, rpm numerator, controller states and control structs.
// ----------------------------------------------------------------------------
package qt_pkg;

  // Sectors-per-revolution register width
  localparam int unsigned SprWidth   = 8;
  // Quotient (rpm) width and the numerator it is taken from
  localparam int unsigned QuotWidth  = 16;
  localparam logic [QuotWidth-1:0] RpmNumerator = 16'd60000;
  // Divider step counter, one quotient bit per step
  localparam int unsigned StepWidth  = $clog2(QuotWidth);
  // Direction width (signed -1, 0, +1)
  localparam int unsigned DirWidth   = 2;

  typedef logic signed [DirWidth-1:0] qt_dir_t;

  typedef enum logic [1:0] {
    QT_IDLE,
    QT_DIV,
    QT_FIN
  } qt_state_e;

  // Controller to datapath
  typedef struct packed {
    logic take;          // input item transfer
    logic div_step;      // one restoring-division step
    logic out_from_item; // load result register straight from the item
    logic out_from_div;  // load result register from the divider
  } qt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic need_div;      // current item is a stop edge with non-zero period
    logic div_last;      // final divider step in progress
  } qt_status_t;

  // Quadrature table indexed by {old_a, old_b, new_a, new_b}
  function automatic qt_dir_t dir_lookup(input logic [3:0] idx);
    qt_dir_t d;
    case (idx)
      4'd1, 4'd7, 4'd8, 4'd14:   d = 2'sd1;
      4'd2, 4'd4, 4'd11, 4'd13:  d = -2'sd1;
      default:                   d = 2'sd0;
    endcase
    return d;
  endfunction

endpackage

### rtl/qt_if.sv
// ----------------------------------------------------------------------------
// qt interfaces
// Valid/ready channels for input items, result items and configuration.
// ----------------------------------------------------------------------------
interface qt_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic edge_a;
  logic edge_b;
  modport source (output valid, output operation, output edge_a, output edge_b,
                  input ready);
  modport sink   (input valid, input operation, input edge_a, input edge_b,
                  output ready);
endinterface

interface qt_out_if;
  logic               valid;
  logic               ready;
  logic signed [1:0]  turn_direction;
  logic [15:0]        speed_rpm;
  logic               rpm_updated;
  logic               zero_period;
  modport source (output valid, output turn_direction, output speed_rpm,
                  output rpm_updated, output zero_period, input ready);
  modport sink   (input valid, input turn_direction, input speed_rpm,
                  input rpm_updated, input zero_period, output ready);
endinterface

interface qt_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] sectors_per_rev;
  modport source (output valid, output sectors_per_rev, input ready);
  modport sink   (input valid, input sectors_per_rev, output ready);
endinterface

### rtl/qt_datapath.sv
// ----------------------------------------------------------------------------
// qt_datapath
// Phase tracking, millisecond counter, period product, bit-serial restoring
// divider and the result register.
// ----------------------------------------------------------------------------
module qt_datapath import qt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  qt_cmd_t             cmd_i,
  output qt_status_t          status_o,
  input  logic                operation_i,
  input  logic                edge_a_i,
  input  logic                edge_b_i,
  input  logic                cfg_we_i,
  input  logic [SprWidth-1:0] cfg_data_i,
  output qt_dir_t             turn_direction_o,
  output logic [QuotWidth-1:0] speed_rpm_o,
  output logic                rpm_updated_o,
  output logic                zero_period_o
);

  localparam int unsigned DivWidth = COUNT_WIDTH + SprWidth;

  // Architectural state
  logic [SprWidth-1:0]    spr_q;
  logic                   phase_a_q, phase_b_q;
  logic                   measuring_q;
  logic [COUNT_WIDTH-1:0] ms_count_q;
  logic [QuotWidth-1:0]   rpm_q;
  qt_dir_t                dir_q;

  // Divider state
  logic [DivWidth-1:0]    div_q;
  logic [DivWidth-1:0]    rem_q, rem_d;
  logic [QuotWidth-1:0]   quo_q, quo_d;
  logic [StepWidth-1:0]   step_q;

  // Result register
  qt_dir_t                res_dir_q;
  logic [QuotWidth-1:0]   res_rpm_q;
  logic                   res_upd_q;
  logic                   res_zero_q;

  logic                   is_edge, stop, nonzero;
  logic                   new_a, new_b;
  qt_dir_t                dir_new, dir_now;
  logic [DivWidth-1:0]    prod;
  logic [DivWidth:0]      trial, trial_sub;

  // Item decode
  assign is_edge = operation_i & (edge_a_i | edge_b_i);
  assign stop    = is_edge & measuring_q;
  assign nonzero = (ms_count_q != '0) && (spr_q != '0);
  assign new_a   = phase_a_q ^ (edge_a_i & ~edge_b_i);
  assign new_b   = phase_b_q ^ (edge_b_i & ~edge_a_i);
  assign dir_new = dir_lookup({phase_a_q, phase_b_q, new_a, new_b});
  assign dir_now = is_edge ? dir_new : dir_q;

  assign status_o.need_div = stop & nonzero;
  assign status_o.div_last = (step_q == '1);

  // Period product: counted ms times sectors
  assign prod = DivWidth'(ms_count_q) * DivWidth'(spr_q);

  // Restoring divider step
  assign trial     = {rem_q, quo_q[QuotWidth-1]};
  assign trial_sub = trial - {1'b0, div_q};
  always_comb begin
    if (trial >= {1'b0, div_q}) begin
      rem_d = trial_sub[DivWidth-1:0];
      quo_d = {quo_q[QuotWidth-2:0], 1'b1};
    end else begin
      rem_d = trial[DivWidth-1:0];
      quo_d = {quo_q[QuotWidth-2:0], 1'b0};
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spr_q <= SprWidth'(24);
    end else if (cfg_we_i) begin
      spr_q <= cfg_data_i;
    end
  end

  // Phases, measurement window and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_a_q   <= 1'b0;
      phase_b_q   <= 1'b0;
      measuring_q <= 1'b0;
      ms_count_q  <= '0;
      dir_q       <= '0;
    end else if (cmd_i.take) begin
      if (!operation_i) begin
        if (measuring_q && (ms_count_q != '1)) begin
          ms_count_q <= ms_count_q + 1'b1;
        end
      end else if (is_edge) begin
        measuring_q <= ~measuring_q;
        if (measuring_q) begin
          ms_count_q <= '0;
        end
        phase_a_q <= new_a;
        phase_b_q <= new_b;
        dir_q     <= dir_new;
      end
    end
  end

  // Held rpm
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpm_q <= '0;
    end else if (cmd_i.out_from_div) begin
      rpm_q <= quo_q;
    end
  end

  // Divider registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.take) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      div_q <= prod;
      rem_q <= '0;
      quo_q <= RpmNumerator;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_from_item) begin
      res_dir_q  <= dir_now;
      res_rpm_q  <= rpm_q;
      res_upd_q  <= 1'b0;
      res_zero_q <= stop & ~nonzero;
    end else if (cmd_i.out_from_div) begin
      res_dir_q  <= dir_q;
      res_rpm_q  <= quo_q;
      res_upd_q  <= 1'b1;
      res_zero_q <= 1'b0;
    end
  end

  assign turn_direction_o = res_dir_q;
  assign speed_rpm_o      = res_rpm_q;
  assign rpm_updated_o    = res_upd_q;
  assign zero_period_o    = res_zero_q;

endmodule

### rtl/qt_ctrl.sv
// ----------------------------------------------------------------------------
// qt_ctrl
// Sequencer: takes items, runs the divider for stop edges and manages the
// result register's valid flag.
// ----------------------------------------------------------------------------
module qt_ctrl import qt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  qt_status_t status_i,
  output qt_cmd_t    cmd_o,
  output qt_state_e  state_o
);

  qt_state_e state_q, state_d;
  logic      out_valid_q, out_valid_d;
  logic      slot_free;

  // Result slot can take a new value this cycle
  assign slot_free = ~out_valid_q | out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= QT_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      QT_IDLE: begin
        in_ready_o = slot_free;
        if (in_valid_i && slot_free) begin
          cmd_o.take = 1'b1;
          if (status_i.need_div) begin
            state_d = QT_DIV;
          end else begin
            cmd_o.out_from_item = 1'b1;
          end
        end
      end
      QT_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = QT_FIN;
        end
      end
      QT_FIN: begin
        if (slot_free) begin
          cmd_o.out_from_div = 1'b1;
          state_d            = QT_IDLE;
        end
      end
      default: begin
        state_d = QT_IDLE;
      end
    endcase

    if (cmd_o.out_from_item || cmd_o.out_from_div) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign state_o     = state_q;

endmodule

### rtl/quadrature_tachometer.sv
// ----------------------------------------------------------------------------
// quadrature_tachometer
// Quadrature decoder with period-based rpm measurement.
// ----------------------------------------------------------------------------
// Every input item (millisecond tick or sensor edge event) yields exactly one
// result. Ticks, edge events that start a measurement, events without an edge
// and stop edges with a zero period land in the result register at once. For
// a stop edge with a non-zero period the period product (count times sectors
// per revolution) is registered when the item is taken, the restoring divider
// produces one bit of 60000 / product per cycle, and the result is loaded once
// the result register is free. A new item is taken whenever the sequencer is
// idle and the result register is empty or being drained in the same cycle.
// The configuration channel is always ready; write it only while idle.
module quadrature_tachometer import qt_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  qt_in_if.sink     in_i,
  qt_out_if.source  out_o,
  qt_cfg_if.sink    cfg_i
);

  qt_cmd_t    cmd;
  qt_status_t status;
  qt_state_e  state;

  assign cfg_i.ready = 1'b1;

  qt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd),
    .state_o     (state)
  );

  qt_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .operation_i      (in_i.operation),
    .edge_a_i         (in_i.edge_a),
    .edge_b_i         (in_i.edge_b),
    .cfg_we_i         (cfg_i.valid),
    .cfg_data_i       (cfg_i.sectors_per_rev),
    .turn_direction_o (out_o.turn_direction),
    .speed_rpm_o      (out_o.speed_rpm),
    .rpm_updated_o    (out_o.rpm_updated),
    .zero_period_o    (out_o.zero_period)
  );

  // A result is either a fresh rpm or a zero-period report, never both
  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.rpm_updated && out_o.zero_period))
    else $error("rpm_updated and zero_period both set");

  // A transferred item either has its result waiting or the divider running
  a_item_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (out_o.valid || state == QT_DIV))
    else $error("accepted item produced neither result nor division");

  // No item is taken while a division is in flight
  a_busy_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state == QT_DIV || state == QT_FIN) |-> !in_i.ready)
    else $error("input ready during division");

endmodule
